// ===== hdl/assert_macros.svh =====
// Assertion helpers used by the line index RTL.
// Each macro samples on clk and is disabled while rst_n is low.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle implication.
`define ASSERT_IMPLY(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication.
`define ASSERT_NEXT(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

// ===== hdl/tlil_pkg.sv =====
// Package for the text line index and lookup core.
// Holds command and status codes, character codes, the controller state type
// and the command/status structs between controller and datapath. No dependencies.
`default_nettype none

package tlil_pkg;

    localparam int CMD_W    = 3;
    localparam int CHAR_W   = 16;
    localparam int STATUS_W = 2;

    // Item commands
    localparam logic [CMD_W-1:0] CMD_CHAR       = 3'd0;
    localparam logic [CMD_W-1:0] CMD_END        = 3'd1;
    localparam logic [CMD_W-1:0] CMD_POS_QUERY  = 3'd2;
    localparam logic [CMD_W-1:0] CMD_LINE_QUERY = 3'd3;
    localparam logic [CMD_W-1:0] CMD_CLEAR      = 3'd4;

    // Result status codes
    localparam logic [STATUS_W-1:0] STATUS_OK    = 2'd0;
    localparam logic [STATUS_W-1:0] STATUS_FULL  = 2'd1;
    localparam logic [STATUS_W-1:0] STATUS_RANGE = 2'd2;

    // Line terminators
    localparam logic [CHAR_W-1:0] CH_CR = 16'd13;
    localparam logic [CHAR_W-1:0] CH_LF = 16'd10;

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_SEARCH,
        ST_COMPARE,
        ST_FINISH
    } state_t;

    // Controller to datapath
    typedef struct packed {
        logic take_item;      // word accepted this cycle
        logic search_step;    // read the midpoint line start
        logic search_update;  // narrow the search window
        logic fetch_issue;    // read the found entry
        logic finish;         // load the result from table read data
    } ctrl_cmd_t;

    // Datapath to controller
    typedef struct packed {
        logic out_free;       // result register can take a word this cycle
        logic deferred;       // current word needs a table read
        logic is_pos_query;   // current word is a position query
        logic search_more;    // search window holds more than one entry
    } dp_status_t;

endpackage

`default_nettype wire

// ===== hdl/tlil_ctrl.sv =====
// Controller for the text line index and lookup core.
// Sequences table reads for queries; uses tlil_pkg command/status structs.
`default_nettype none

module tlil_ctrl
(
    input  wire                    clk,
    input  wire                    rst_n,
    input  wire                    item_valid,
    output logic                   item_stall,
    input  tlil_pkg::dp_status_t   dp_status,
    output tlil_pkg::ctrl_cmd_t    ctrl_cmd
);

    tlil_pkg::state_t state_reg;
    tlil_pkg::state_t state_next;

    // State register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= tlil_pkg::ST_IDLE;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

    // Next state and commands
    always_comb
    begin
        state_next = state_reg;
        ctrl_cmd   = '0;
        item_stall = 1'b1;
        unique case (state_reg)
            tlil_pkg::ST_IDLE:
            begin
                item_stall = !dp_status.out_free;
                if (item_valid && dp_status.out_free)
                begin
                    ctrl_cmd.take_item = 1'b1;
                    if (dp_status.deferred)
                    begin
                        state_next = dp_status.is_pos_query ? tlil_pkg::ST_SEARCH
                                                            : tlil_pkg::ST_FINISH;
                    end
                end
            end
            tlil_pkg::ST_SEARCH:
            begin
                if (dp_status.search_more)
                begin
                    ctrl_cmd.search_step = 1'b1;
                    state_next           = tlil_pkg::ST_COMPARE;
                end
                else
                begin
                    ctrl_cmd.fetch_issue = 1'b1;
                    state_next           = tlil_pkg::ST_FINISH;
                end
            end
            tlil_pkg::ST_COMPARE:
            begin
                ctrl_cmd.search_update = 1'b1;
                state_next             = tlil_pkg::ST_SEARCH;
            end
            tlil_pkg::ST_FINISH:
            begin
                ctrl_cmd.finish = 1'b1;
                state_next      = tlil_pkg::ST_IDLE;
            end
            default:
            begin
                state_next = tlil_pkg::ST_IDLE;
            end
        endcase
    end

endmodule

`default_nettype wire

// ===== hdl/tlil_datapath.sv =====
// Datapath for the text line index and lookup core: position tracking,
// line table memory, binary search registers and result register. Uses tlil_pkg.
`default_nettype none

module tlil_datapath
#(
    parameter int MAX_LINES = 4096,
    parameter int POS_BITS  = 20
)
(
    input  wire                               clk,
    input  wire                               rst_n,
    input  tlil_pkg::ctrl_cmd_t               ctrl_cmd,
    output tlil_pkg::dp_status_t              dp_status,
    input  wire  [tlil_pkg::CMD_W-1:0]        command,
    input  wire  [tlil_pkg::CHAR_W-1:0]       char_code,
    input  wire  [POS_BITS-1:0]               position,
    input  wire  [POS_BITS:0]                 line_query,
    input  wire                               offset_write,
    input  wire  [POS_BITS-1:0]               offset_data,
    output logic                              result_valid,
    input  wire                               result_stall,
    output logic [POS_BITS:0]                 line_number,
    output logic [POS_BITS-1:0]               line_start,
    output logic [POS_BITS-1:0]               line_length,
    output logic [$clog2(MAX_LINES+1)-1:0]    line_total,
    output logic                              line_recorded,
    output logic [tlil_pkg::STATUS_W-1:0]     status
);

    localparam int CNT_W = $clog2(MAX_LINES + 1);
    localparam int IDX_W = $clog2(MAX_LINES);
    localparam int LQ_W  = POS_BITS + 1;
    localparam int SUM_W = ((CNT_W > POS_BITS) ? CNT_W : POS_BITS) + 1;
    localparam int CMP_W = (CNT_W > LQ_W) ? CNT_W : LQ_W;

    // Text tracking state
    logic [POS_BITS-1:0] offset_reg;
    logic [POS_BITS-1:0] char_pos_reg, char_pos_next;
    logic [POS_BITS-1:0] line_start_reg, line_start_next;
    logic                pending_cr_reg, pending_cr_next;
    logic [CNT_W-1:0]    line_count_reg, line_count_next;

    // Search state
    logic [CNT_W-1:0]    s_reg, e_reg;
    logic [CNT_W-1:0]    mid_reg;
    logic [POS_BITS-1:0] key_reg;
    logic [LQ_W-1:0]     num_reg;
    logic                hit_reg;

    // Line table: start in the upper half, length in the lower half
    logic [2*POS_BITS-1:0] mem [MAX_LINES];
    logic [2*POS_BITS-1:0] rd_data_reg;
    logic [IDX_W-1:0]      rd_addr;
    logic                  wr_en;

    // Result register
    logic                         out_valid_reg;
    logic [LQ_W-1:0]              out_number_reg;
    logic [POS_BITS-1:0]          out_start_reg;
    logic [POS_BITS-1:0]          out_length_reg;
    logic [CNT_W-1:0]             out_total_reg;
    logic                         out_recorded_reg;
    logic [tlil_pkg::STATUS_W-1:0] out_status_reg;

    logic [POS_BITS-1:0] pos_inc;
    logic [POS_BITS-1:0] cur_len;
    logic                table_room;
    logic                is_cr, is_lf;
    logic                close_line;
    logic [LQ_W:0]       lq_diff;
    logic [CMP_W-1:0]    lq_rel;
    logic                lq_hit;
    logic [IDX_W-1:0]    lq_idx;
    logic [CNT_W-1:0]    span;
    logic [CNT_W-1:0]    mid;
    logic [SUM_W-1:0]    found_sum;
    logic [POS_BITS-1:0] rd_start, rd_length;
    logic                load_now;
    logic                load_out;

    assign pos_inc    = (&char_pos_reg) ? char_pos_reg : char_pos_reg + POS_BITS'(1);
    assign cur_len    = char_pos_reg - line_start_reg;
    assign table_room = line_count_reg < CNT_W'(MAX_LINES);
    assign is_cr      = char_code == tlil_pkg::CH_CR;
    assign is_lf      = char_code == tlil_pkg::CH_LF;

    // Line query bounds: below offset borrows, at or past count is out
    assign lq_diff = {1'b0, line_query} - (LQ_W + 1)'(offset_reg);
    assign lq_rel  = CMP_W'(lq_diff[LQ_W-1:0]);
    assign lq_hit  = !lq_diff[LQ_W] && (lq_rel < CMP_W'(line_count_reg));
    assign lq_idx  = lq_rel[IDX_W-1:0];

    // Search window midpoint
    assign span      = e_reg - s_reg;
    assign mid       = s_reg + (span >> 1);
    assign found_sum = SUM_W'(s_reg) + SUM_W'(offset_reg);

    assign rd_start  = rd_data_reg[2*POS_BITS-1:POS_BITS];
    assign rd_length = rd_data_reg[POS_BITS-1:0];

    // Status to controller
    assign dp_status.out_free     = !out_valid_reg || !result_stall;
    assign dp_status.is_pos_query = command == tlil_pkg::CMD_POS_QUERY;
    assign dp_status.deferred     = (command == tlil_pkg::CMD_POS_QUERY) ||
                                    ((command == tlil_pkg::CMD_LINE_QUERY) && lq_hit);
    assign dp_status.search_more  = span > CNT_W'(1);

    // Character, end and clear handling
    always_comb
    begin
        char_pos_next   = char_pos_reg;
        line_start_next = line_start_reg;
        pending_cr_next = pending_cr_reg;
        close_line      = 1'b0;
        unique case (command)
            tlil_pkg::CMD_CHAR:
            begin
                if (pending_cr_reg && is_lf)
                begin
                    // LF of a CR LF pair: skip past it
                    pending_cr_next = 1'b0;
                    char_pos_next   = pos_inc;
                    line_start_next = pos_inc;
                end
                else if (is_cr || is_lf)
                begin
                    close_line      = 1'b1;
                    pending_cr_next = is_cr;
                    char_pos_next   = pos_inc;
                    line_start_next = pos_inc;
                end
                else
                begin
                    pending_cr_next = 1'b0;
                    char_pos_next   = pos_inc;
                end
            end
            tlil_pkg::CMD_END:
            begin
                pending_cr_next = 1'b0;
                close_line      = char_pos_reg != line_start_reg;
                line_start_next = char_pos_reg;
            end
            tlil_pkg::CMD_CLEAR:
            begin
                pending_cr_next = 1'b0;
                char_pos_next   = '0;
                line_start_next = '0;
            end
            default:
            begin
                close_line = 1'b0;
            end
        endcase
    end

    assign wr_en = ctrl_cmd.take_item && close_line && table_room;

    always_comb
    begin
        line_count_next = line_count_reg;
        if (command == tlil_pkg::CMD_CLEAR)
        begin
            line_count_next = '0;
        end
        else if (close_line && table_room)
        begin
            line_count_next = line_count_reg + CNT_W'(1);
        end
    end

    // Text tracking registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            offset_reg     <= '0;
            char_pos_reg   <= '0;
            line_start_reg <= '0;
            pending_cr_reg <= 1'b0;
            line_count_reg <= '0;
        end
        else
        begin
            if (offset_write)
            begin
                offset_reg <= offset_data;
            end
            if (ctrl_cmd.take_item)
            begin
                char_pos_reg   <= char_pos_next;
                line_start_reg <= line_start_next;
                pending_cr_reg <= pending_cr_next;
                line_count_reg <= line_count_next;
            end
        end
    end

    // Read address: midpoint, found entry or queried line
    always_comb
    begin
        priority if (ctrl_cmd.search_step)
        begin
            rd_addr = mid[IDX_W-1:0];
        end
        else if (ctrl_cmd.fetch_issue)
        begin
            rd_addr = s_reg[IDX_W-1:0];
        end
        else
        begin
            rd_addr = lq_idx;
        end
    end

    // Line table memory, registered read
    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem[line_count_reg[IDX_W-1:0]] <= {line_start_reg, cur_len};
        end
        rd_data_reg <= mem[rd_addr];
    end

    // Binary search and lookup registers
    always_ff @(posedge clk)
    begin
        if (ctrl_cmd.take_item)
        begin
            key_reg <= position;
            s_reg   <= '0;
            e_reg   <= line_count_reg;
            num_reg <= line_query;
            hit_reg <= 1'b1;
        end
        if (ctrl_cmd.search_step)
        begin
            mid_reg <= mid;
        end
        if (ctrl_cmd.search_update)
        begin
            if (rd_start > key_reg)
            begin
                e_reg <= mid_reg;
            end
            else
            begin
                s_reg <= mid_reg;
            end
        end
        if (ctrl_cmd.fetch_issue)
        begin
            num_reg <= found_sum[LQ_W-1:0];
            hit_reg <= line_count_reg != '0;
        end
    end

    assign load_now = ctrl_cmd.take_item && !dp_status.deferred;
    assign load_out = load_now || ctrl_cmd.finish;

    // Result valid flag
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else if (load_out)
        begin
            out_valid_reg <= 1'b1;
        end
        else if (!result_stall)
        begin
            out_valid_reg <= 1'b0;
        end
    end

    // Result word
    always_ff @(posedge clk)
    begin
        if (ctrl_cmd.finish)
        begin
            out_number_reg   <= num_reg;
            out_start_reg    <= hit_reg ? rd_start : '0;
            out_length_reg   <= hit_reg ? rd_length : '0;
            out_total_reg    <= line_count_reg;
            out_recorded_reg <= 1'b0;
            out_status_reg   <= tlil_pkg::STATUS_OK;
        end
        else if (load_now)
        begin
            out_number_reg   <= '0;
            out_start_reg    <= close_line ? line_start_reg : '0;
            out_length_reg   <= close_line ? cur_len : '0;
            out_total_reg    <= line_count_next;
            out_recorded_reg <= close_line && table_room;
            if (close_line && !table_room)
            begin
                out_status_reg <= tlil_pkg::STATUS_FULL;
            end
            else if (command == tlil_pkg::CMD_LINE_QUERY)
            begin
                out_status_reg <= tlil_pkg::STATUS_RANGE;
            end
            else
            begin
                out_status_reg <= tlil_pkg::STATUS_OK;
            end
        end
    end

    assign result_valid  = out_valid_reg;
    assign line_number   = out_number_reg;
    assign line_start    = out_start_reg;
    assign line_length   = out_length_reg;
    assign line_total    = out_total_reg;
    assign line_recorded = out_recorded_reg;
    assign status        = out_status_reg;

endmodule

`default_nettype wire

// ===== hdl/text_line_index_and_lookup_core.sv =====
// Text line index and lookup core: a character stream is cut into lines at CR,
// LF or CR LF, each line's start and length goes into a MAX_LINES entry table,
// and position and line queries are answered from that table. A character, end,
// clear or ignored command word needs no table read and can follow the previous
// word in the next cycle, as long as the result register is free or being emptied.
// A line query out of range is answered the same way; one in range reads the line
// table first. A position query runs k halving steps of the binary search (about
// log2 of the lines stored), each a SEARCH and a COMPARE state on the single read
// port of the line table, then fetches the found entry. The line table is not
// cleared at reset: only entries below the stored line count reach the result.
// Depends on tlil_pkg, tlil_ctrl, tlil_datapath and assert_macros.svh.
`default_nettype none

`include "assert_macros.svh"

module text_line_index_and_lookup_core
#(
    parameter int MAX_LINES = 4096,
    parameter int POS_BITS  = 20
)
(
    input  wire                               clk,
    input  wire                               rst_n,
    input  wire                               item_valid,
    output logic                              item_stall,
    input  wire  [tlil_pkg::CMD_W-1:0]        command,
    input  wire  [tlil_pkg::CHAR_W-1:0]       char_code,
    input  wire  [POS_BITS-1:0]               position,
    input  wire  [POS_BITS:0]                 line_query,
    input  wire                               offset_write,
    input  wire  [POS_BITS-1:0]               offset_data,
    output logic                              result_valid,
    input  wire                               result_stall,
    output logic [POS_BITS:0]                 line_number,
    output logic [POS_BITS-1:0]               line_start,
    output logic [POS_BITS-1:0]               line_length,
    output logic [$clog2(MAX_LINES+1)-1:0]    line_total,
    output logic                              line_recorded,
    output logic [tlil_pkg::STATUS_W-1:0]     status
);

    localparam int CNT_W = $clog2(MAX_LINES + 1);

    tlil_pkg::ctrl_cmd_t  ctrl_cmd;
    tlil_pkg::dp_status_t dp_status;

    tlil_ctrl u_ctrl
    (
        .clk        (clk),
        .rst_n      (rst_n),
        .item_valid (item_valid),
        .item_stall (item_stall),
        .dp_status  (dp_status),
        .ctrl_cmd   (ctrl_cmd)
    );

    tlil_datapath
    #(
        .MAX_LINES (MAX_LINES),
        .POS_BITS  (POS_BITS)
    )
    u_datapath
    (
        .clk           (clk),
        .rst_n         (rst_n),
        .ctrl_cmd      (ctrl_cmd),
        .dp_status     (dp_status),
        .command       (command),
        .char_code     (char_code),
        .position      (position),
        .line_query    (line_query),
        .offset_write  (offset_write),
        .offset_data   (offset_data),
        .result_valid  (result_valid),
        .result_stall  (result_stall),
        .line_number   (line_number),
        .line_start    (line_start),
        .line_length   (line_length),
        .line_total    (line_total),
        .line_recorded (line_recorded),
        .status        (status)
    );

    // Checks
    `ASSERT_IMPLY(a_no_overrun, item_valid && !item_stall, !(result_valid && result_stall), "word accepted while result register blocked")
    `ASSERT_IMPLY(a_total_bound, result_valid, line_total <= CNT_W'(MAX_LINES), "line total above table depth")
    `ASSERT_IMPLY(a_recorded_ok, result_valid && line_recorded, status == tlil_pkg::STATUS_OK, "recorded line with error status")
    `ASSERT_NEXT(a_finish_loads, ctrl_cmd.finish, result_valid, "lookup finished without a result")
    `ASSERT_NEXT(a_search_stalls, item_valid && !item_stall && command == tlil_pkg::CMD_POS_QUERY, item_stall, "input open during position search")

endmodule

`default_nettype wire

// ===== dv/tb_text_line_index_and_lookup_core.sv =====
// Self-checking testbench for text_line_index_and_lookup_core: line cutting, ignored
// commands, position and line queries and the offset register against a local
// predictor. Depends on tlil_pkg and the core RTL only.
`timescale 1ns / 100ps
`default_nettype none

module tb_text_line_index_and_lookup_core;

    localparam int MAX_LINES = 4096;
    localparam int POS_BITS  = 20;
    localparam int TOTAL_W   = $clog2(MAX_LINES + 1);
    localparam logic [POS_BITS-1:0] POS_TOP = {POS_BITS{1'b1}};

    // Command codes the core ignores
    localparam logic [tlil_pkg::CMD_W-1:0] CMD_SPARE_5 = 3'd5;
    localparam logic [tlil_pkg::CMD_W-1:0] CMD_SPARE_6 = 3'd6;
    localparam logic [tlil_pkg::CMD_W-1:0] CMD_SPARE_7 = 3'd7;

    localparam int DIR_ROWS = 26;

    typedef enum {IDLE_NONE, IDLE_SENDER, IDLE_RECEIVER, IDLE_BOTH} idle_mode_t;

    typedef struct packed {
        logic [POS_BITS:0]             line_num;
        logic [POS_BITS-1:0]           line_beg;
        logic [POS_BITS-1:0]           line_len;
        logic [TOTAL_W-1:0]            total;
        logic                          recorded;
        logic [tlil_pkg::STATUS_W-1:0] status;
    } line_result_t;

    // One directed word; w_* fields hold a typed-in result when fixed is set
    typedef struct packed {
        logic [tlil_pkg::CMD_W-1:0]    cmd;
        logic [tlil_pkg::CHAR_W-1:0]   ch;
        logic [POS_BITS-1:0]           pos;
        logic [POS_BITS:0]             lq;
        logic                          fixed;
        logic [POS_BITS:0]             w_num;
        logic [POS_BITS-1:0]           w_beg;
        logic [POS_BITS-1:0]           w_len;
        logic [TOTAL_W-1:0]            w_total;
        logic                          w_rec;
        logic [tlil_pkg::STATUS_W-1:0] w_status;
    } stim_row_t;

    logic                          clk = 1'b0;
    logic                          rst_n = 1'b0;
    logic                          item_valid = 1'b0;
    logic                          item_stall;
    logic [tlil_pkg::CMD_W-1:0]    command = tlil_pkg::CMD_CHAR;
    logic [tlil_pkg::CHAR_W-1:0]   char_code = '0;
    logic [POS_BITS-1:0]           position = '0;
    logic [POS_BITS:0]             line_query = '0;
    logic                          offset_write = 1'b0;
    logic [POS_BITS-1:0]           offset_data = '0;
    logic                          result_valid;
    logic                          result_stall = 1'b0;
    logic [POS_BITS:0]             line_number;
    logic [POS_BITS-1:0]           line_start;
    logic [POS_BITS-1:0]           line_length;
    logic [TOTAL_W-1:0]            line_total;
    logic                          line_recorded;
    logic [tlil_pkg::STATUS_W-1:0] status;

    // Predictor state
    logic [POS_BITS-1:0]       offset_reg = '0;
    logic [POS_BITS-1:0]       char_pos = '0;
    logic [POS_BITS-1:0]       line_begin = '0;
    logic                      cr_pending = 1'b0;
    int unsigned               line_count = 0;
    logic [POS_BITS-1:0]       start_mem [MAX_LINES];
    logic [POS_BITS-1:0]       length_mem [MAX_LINES];

    line_result_t              pending_lines [$];
    logic                      use_fixed = 1'b0;
    line_result_t              fixed_want = '0;
    int unsigned               sender_gap_pct = 0;
    int unsigned               receiver_stall_pct = 0;
    int unsigned               mismatch_count = 0;

    text_line_index_and_lookup_core #(
        .MAX_LINES (MAX_LINES),
        .POS_BITS  (POS_BITS)
    ) DUT (
        .clk           (clk),
        .rst_n         (rst_n),
        .item_valid    (item_valid),
        .item_stall    (item_stall),
        .command       (command),
        .char_code     (char_code),
        .position      (position),
        .line_query    (line_query),
        .offset_write  (offset_write),
        .offset_data   (offset_data),
        .result_valid  (result_valid),
        .result_stall  (result_stall),
        .line_number   (line_number),
        .line_start    (line_start),
        .line_length   (line_length),
        .line_total    (line_total),
        .line_recorded (line_recorded),
        .status        (status)
    );

    always
    begin
        #5 clk = 1'b1;
        #5 clk = 1'b0;
    end

    // Hard stop in case the core hangs
    initial
    begin
        #60_000_000;
        $display("DONE: errors detected");
        $finish;
    end

    function automatic logic [POS_BITS-1:0] bump_pos(input logic [POS_BITS-1:0] p);
        return (p == POS_TOP) ? POS_TOP : p + 1'b1;
    endfunction

    // Close the open line: store it if there is room, else flag it as dropped
    function automatic void close_line(inout line_result_t r);
        logic [POS_BITS-1:0] len;
        len = char_pos - line_begin;
        r.line_beg = line_begin;
        r.line_len = len;
        if (line_count < MAX_LINES)
        begin
            start_mem[line_count] = line_begin;
            length_mem[line_count] = len;
            line_count++;
            r.recorded = 1'b1;
        end
        else
            r.status = tlil_pkg::STATUS_FULL;
    endfunction

    // Advance the predictor by one accepted word and return its result
    function automatic line_result_t step_line_index(input logic [tlil_pkg::CMD_W-1:0] cmd,
        input logic [tlil_pkg::CHAR_W-1:0] ch, input logic [POS_BITS-1:0] pos,
        input logic [POS_BITS:0] lq);
        line_result_t r;
        int unsigned  lo;
        int unsigned  hi;
        int unsigned  mid;
        int unsigned  lq_i;
        int unsigned  off_i;
        r = '0;
        lq_i = 32'(lq);
        off_i = 32'(offset_reg);
        case (cmd)
            tlil_pkg::CMD_CHAR:
            begin
                if (cr_pending && ch == tlil_pkg::CH_LF)
                begin
                    // second half of CR LF: skip past it, record nothing
                    cr_pending = 1'b0;
                    char_pos = bump_pos(char_pos);
                    line_begin = char_pos;
                end
                else
                begin
                    cr_pending = 1'b0;
                    if (ch == tlil_pkg::CH_CR || ch == tlil_pkg::CH_LF)
                    begin
                        close_line(r);
                        cr_pending = (ch == tlil_pkg::CH_CR);
                        char_pos = bump_pos(char_pos);
                        line_begin = char_pos;
                    end
                    else
                        char_pos = bump_pos(char_pos);
                end
            end
            tlil_pkg::CMD_END:
            begin
                cr_pending = 1'b0;
                if (char_pos != line_begin)
                    close_line(r);
                line_begin = char_pos;
            end
            tlil_pkg::CMD_POS_QUERY:
            begin
                lo = 0;
                hi = line_count;
                while (hi - lo > 1)
                begin
                    mid = lo + (hi - lo) / 2;
                    if (start_mem[mid] > pos)
                        hi = mid;
                    else
                        lo = mid;
                end
                r.line_num = (POS_BITS + 1)'(lo + off_i);
                if (line_count > 0)
                begin
                    r.line_beg = start_mem[lo];
                    r.line_len = length_mem[lo];
                end
            end
            tlil_pkg::CMD_LINE_QUERY:
            begin
                if (lq_i >= off_i && lq_i - off_i < line_count)
                begin
                    r.line_num = lq;
                    r.line_beg = start_mem[lq_i - off_i];
                    r.line_len = length_mem[lq_i - off_i];
                end
                else
                    r.status = tlil_pkg::STATUS_RANGE;
            end
            tlil_pkg::CMD_CLEAR:
            begin
                line_count = 0;
                char_pos = '0;
                line_begin = '0;
                cr_pending = 1'b0;
            end
            default:
            begin
            end
        endcase
        r.total = TOTAL_W'(line_count);
        return r;
    endfunction

    task automatic check_field(input string name, input logic [31:0] want,
        input logic [31:0] got);
        if (got !== want)
        begin
            $display("%0t ns: %s expected %0d, got %0d", $time, name, want, got);
            mismatch_count++;
        end
    endtask

    // Predict on accepted words, check accepted results against the oldest expectation
    always @(posedge clk)
    begin
        line_result_t predicted;
        line_result_t want;
        if (rst_n)
        begin
            if (item_valid && !item_stall)
            begin
                predicted = step_line_index(command, char_code, position, line_query);
                pending_lines.insert(pending_lines.size(), use_fixed ? fixed_want : predicted);
            end
            if (result_valid && !result_stall)
            begin
                if (pending_lines.size() == 0)
                begin
                    $display("%0t ns: result word with none expected, line_number %0d",
                             $time, line_number);
                    mismatch_count++;
                end
                else
                begin
                    want = pending_lines.pop_front();
                    check_field("line_number", 32'(want.line_num), 32'(line_number));
                    check_field("line_start", 32'(want.line_beg), 32'(line_start));
                    check_field("line_length", 32'(want.line_len), 32'(line_length));
                    check_field("line_total", 32'(want.total), 32'(line_total));
                    check_field("line_recorded", 32'(want.recorded), 32'(line_recorded));
                    check_field("status", 32'(want.status), 32'(status));
                end
            end
        end
    end

    // Drive receiver back-pressure
    always @(negedge clk)
    begin
        result_stall = ($urandom_range(0, 99) < receiver_stall_pct);
    end

    task automatic set_idle(input idle_mode_t mode);
        sender_gap_pct = (mode == IDLE_SENDER) ? 46 : (mode == IDLE_BOTH) ? 11 : 0;
        receiver_stall_pct = (mode == IDLE_RECEIVER) ? 46 : (mode == IDLE_BOTH) ? 11 : 0;
    endtask

    // Present one word at the falling edge and hold it until accepted
    task automatic send_word(input logic [tlil_pkg::CMD_W-1:0] cmd,
        input logic [tlil_pkg::CHAR_W-1:0] ch,
        input logic [POS_BITS-1:0] pos, input logic [POS_BITS:0] lq,
        input logic fixed, input line_result_t want);
        while ($urandom_range(0, 99) < sender_gap_pct)
        begin
            item_valid = 1'b0;
            @(negedge clk);
        end
        item_valid = 1'b1;
        command = cmd;
        char_code = ch;
        position = pos;
        line_query = lq;
        use_fixed = fixed;
        fixed_want = want;
        @(posedge clk);
        while (item_stall)
            @(posedge clk);
        @(negedge clk);
    endtask

    // Drop valid and wait for every expected result
    task automatic settle();
        item_valid = 1'b0;
        while (pending_lines.size() != 0)
            @(negedge clk);
        repeat (4) @(negedge clk);
    endtask

    task automatic write_offset(input logic [POS_BITS-1:0] value);
        offset_write = 1'b1;
        offset_data = value;
        @(posedge clk);
        offset_reg = value;
        @(negedge clk);
        offset_write = 1'b0;
        offset_data = '0;
    endtask

    function automatic logic [tlil_pkg::CHAR_W-1:0] ordinary_char();
        logic [tlil_pkg::CHAR_W-1:0] c;
        c = tlil_pkg::CHAR_W'($urandom);
        if (c == tlil_pkg::CH_CR || c == tlil_pkg::CH_LF)
            c = 16'h0078;
        return c;
    endfunction

    // Pick a word weighted toward line building, with queries aimed at the table
    task automatic send_random_word();
        int unsigned                 sel;
        logic [tlil_pkg::CMD_W-1:0]  cmd;
        logic [tlil_pkg::CHAR_W-1:0] ch;
        logic [POS_BITS-1:0]         pos;
        logic [POS_BITS:0]           lq;
        sel = $urandom_range(0, 99);
        ch = tlil_pkg::CHAR_W'($urandom);
        pos = POS_BITS'($urandom);
        lq = (POS_BITS + 1)'($urandom);
        if (sel < 60)
        begin
            cmd = tlil_pkg::CMD_CHAR;
            case ($urandom_range(0, 9))
                0, 1, 2: ch = tlil_pkg::CH_LF;
                3, 4:    ch = tlil_pkg::CH_CR;
                5:       ch = '0;
                6:       ch = '1;
                default: ch = ordinary_char();
            endcase
        end
        else if (sel < 68)
            cmd = tlil_pkg::CMD_END;
        else if (sel < 80)
        begin
            cmd = tlil_pkg::CMD_POS_QUERY;
            if ($urandom_range(0, 3) != 0)
                pos = POS_BITS'($urandom_range(0, char_pos + 2));
        end
        else if (sel < 93)
        begin
            cmd = tlil_pkg::CMD_LINE_QUERY;
            case ($urandom_range(0, 7))
                6:       lq = (POS_BITS + 1)'(offset_reg - $urandom_range(1, 4));
                7:       lq = (POS_BITS + 1)'($urandom);
                default: lq = (POS_BITS + 1)'(offset_reg + $urandom_range(0, line_count + 1));
            endcase
        end
        else if (sel < 95)
            cmd = tlil_pkg::CMD_CLEAR;
        else
        begin
            case ($urandom_range(0, 2))
                0:       cmd = CMD_SPARE_5;
                1:       cmd = CMD_SPARE_6;
                default: cmd = CMD_SPARE_7;
            endcase
        end
        send_word(cmd, ch, pos, lq, 1'b0, '0);
    endtask

    initial
    begin
        stim_row_t    directed [DIR_ROWS];
        line_result_t want;
        int unsigned  row;
        logic [POS_BITS-1:0] phase_offset [5];

        directed = '{
            // empty table after reset
            '{tlil_pkg::CMD_LINE_QUERY, 16'd0, 20'd0, 21'd0, 1'b1, 21'd0, 20'd0, 20'd0,
              13'd0, 1'b0, tlil_pkg::STATUS_RANGE},
            '{tlil_pkg::CMD_POS_QUERY, 16'd0, 20'd0, 21'd0, 1'b1, 21'd0, 20'd0, 20'd0,
              13'd0, 1'b0, tlil_pkg::STATUS_OK},
            // plain characters, code zero and all ones among them
            '{tlil_pkg::CMD_CHAR, 16'h0061, 20'd0, 21'd0, 1'b1, 21'd0, 20'd0, 20'd0, 13'd0,
              1'b0, tlil_pkg::STATUS_OK},
            '{tlil_pkg::CMD_CHAR, 16'h0000, 20'd0, 21'd0, 1'b1, 21'd0, 20'd0, 20'd0, 13'd0,
              1'b0, tlil_pkg::STATUS_OK},
            '{tlil_pkg::CMD_CHAR, 16'hFFFF, 20'd0, 21'd0, 1'b1, 21'd0, 20'd0, 20'd0, 13'd0,
              1'b0, tlil_pkg::STATUS_OK},
            // CR LF pair, lone LF, CR then other character, CR CR
            '{tlil_pkg::CMD_CHAR, tlil_pkg::CH_CR, 20'd0, 21'd0, 1'b0, 21'd0, 20'd0, 20'd0,
              13'd0, 1'b0, tlil_pkg::STATUS_OK},
            '{tlil_pkg::CMD_CHAR, tlil_pkg::CH_LF, 20'd0, 21'd0, 1'b0, 21'd0, 20'd0, 20'd0,
              13'd0, 1'b0, tlil_pkg::STATUS_OK},
            '{tlil_pkg::CMD_CHAR, tlil_pkg::CH_LF, 20'd0, 21'd0, 1'b0, 21'd0, 20'd0, 20'd0,
              13'd0, 1'b0, tlil_pkg::STATUS_OK},
            '{tlil_pkg::CMD_CHAR, 16'h0062, 20'd0, 21'd0, 1'b0, 21'd0, 20'd0, 20'd0, 13'd0,
              1'b0, tlil_pkg::STATUS_OK},
            '{tlil_pkg::CMD_CHAR, tlil_pkg::CH_CR, 20'd0, 21'd0, 1'b0, 21'd0, 20'd0, 20'd0,
              13'd0, 1'b0, tlil_pkg::STATUS_OK},
            '{tlil_pkg::CMD_CHAR, 16'h0063, 20'd0, 21'd0, 1'b0, 21'd0, 20'd0, 20'd0, 13'd0,
              1'b0, tlil_pkg::STATUS_OK},
            '{tlil_pkg::CMD_CHAR, tlil_pkg::CH_CR, 20'd0, 21'd0, 1'b0, 21'd0, 20'd0, 20'd0,
              13'd0, 1'b0, tlil_pkg::STATUS_OK},
            '{tlil_pkg::CMD_CHAR, tlil_pkg::CH_CR, 20'd0, 21'd0, 1'b0, 21'd0, 20'd0, 20'd0,
              13'd0, 1'b0, tlil_pkg::STATUS_OK},
            '{tlil_pkg::CMD_CHAR, 16'h0064, 20'd0, 21'd0, 1'b0, 21'd0, 20'd0, 20'd0, 13'd0,
              1'b0, tlil_pkg::STATUS_OK},
            // end of text with an open line, then end clearing a pending CR
            '{tlil_pkg::CMD_END, 16'd0, 20'd0, 21'd0, 1'b0, 21'd0, 20'd0, 20'd0, 13'd0,
              1'b0, tlil_pkg::STATUS_OK},
            '{tlil_pkg::CMD_CHAR, tlil_pkg::CH_CR, 20'd0, 21'd0, 1'b0, 21'd0, 20'd0, 20'd0,
              13'd0, 1'b0, tlil_pkg::STATUS_OK},
            '{tlil_pkg::CMD_END, 16'd0, 20'd0, 21'd0, 1'b0, 21'd0, 20'd0, 20'd0, 13'd0,
              1'b0, tlil_pkg::STATUS_OK},
            '{tlil_pkg::CMD_CHAR, tlil_pkg::CH_LF, 20'd0, 21'd0, 1'b0, 21'd0, 20'd0, 20'd0,
              13'd0, 1'b0, tlil_pkg::STATUS_OK},
            // queries over the eight stored lines
            '{tlil_pkg::CMD_POS_QUERY, 16'd0, 20'd5, 21'd0, 1'b0, 21'd0, 20'd0, 20'd0,
              13'd0, 1'b0, tlil_pkg::STATUS_OK},
            '{tlil_pkg::CMD_POS_QUERY, 16'd0, 20'hFFFFF, 21'd0, 1'b0, 21'd0, 20'd0, 20'd0,
              13'd0, 1'b0, tlil_pkg::STATUS_OK},
            '{tlil_pkg::CMD_LINE_QUERY, 16'd0, 20'd0, 21'd7, 1'b0, 21'd0, 20'd0, 20'd0,
              13'd0, 1'b0, tlil_pkg::STATUS_OK},
            '{tlil_pkg::CMD_LINE_QUERY, 16'd0, 20'd0, 21'd8, 1'b1, 21'd0, 20'd0, 20'd0,
              13'd8, 1'b0, tlil_pkg::STATUS_RANGE},
            '{tlil_pkg::CMD_LINE_QUERY, 16'd0, 20'd0, 21'h1FFFFF, 1'b1, 21'd0, 20'd0, 20'd0,
              13'd8, 1'b0, tlil_pkg::STATUS_RANGE},
            // ignored commands, then clear
            '{CMD_SPARE_5, 16'hFFFF, 20'hFFFFF, 21'h1FFFFF, 1'b1, 21'd0, 20'd0, 20'd0, 13'd8,
              1'b0, tlil_pkg::STATUS_OK},
            '{CMD_SPARE_7, 16'hFFFF, 20'hFFFFF, 21'h1FFFFF, 1'b1, 21'd0, 20'd0, 20'd0, 13'd8,
              1'b0, tlil_pkg::STATUS_OK},
            '{tlil_pkg::CMD_CLEAR, 16'd0, 20'd0, 21'd0, 1'b1, 21'd0, 20'd0, 20'd0, 13'd0,
              1'b0, tlil_pkg::STATUS_OK}
        };
        phase_offset = '{20'hFFFFF, 20'd1, POS_BITS'($urandom), 20'd0, POS_BITS'($urandom)};

        // Hold reset low, then release it
        repeat (9) @(negedge clk);
        rst_n = 1'b1;
        @(negedge clk);

        // Directed table
        set_idle(IDLE_NONE);
        for (row = 0; row < DIR_ROWS; row++)
        begin
            want.line_num = directed[row].w_num;
            want.line_beg = directed[row].w_beg;
            want.line_len = directed[row].w_len;
            want.total = directed[row].w_total;
            want.recorded = directed[row].w_rec;
            want.status = directed[row].w_status;
            send_word(directed[row].cmd, directed[row].ch, directed[row].pos,
                      directed[row].lq, directed[row].fixed, want);
        end

        // Random phases, each setting its own offset and an idling mode
        for (row = 0; row < 5; row++)
        begin
            settle();
            write_offset(phase_offset[row]);
            set_idle(idle_mode_t'(row % 4));
            repeat (230) send_random_word();
        end

        // Drain and report
        settle();
        repeat (20) @(negedge clk);
        if (mismatch_count == 0)
            $display("DONE: 0 errors");
        else
            $display("DONE: errors detected");
        $finish;
    end

endmodule

`default_nettype wire
